@@ rtl/hhs_pkg.sv @@
package hhs_pkg;

  localparam int SampleW   = 32;
  localparam int GradW     = 36;
  localparam int GradMagW  = 35;
  localparam int ScaleMagW = 32;
  localparam int AbW       = 55;
  localparam int NormW     = 30;
  localparam int UnitW     = 25;
  localparam int QW        = 62;
  localparam int RootW     = 31;
  localparam int TW        = 33;
  localparam int QuoW      = 18;
  localparam int NormSteps = 5;
  localparam int SqrtSteps = 31;
  localparam int DivSteps  = 18;

  localparam logic [30:0]    Sqrt2Q30   = 31'd1518500250;
  localparam logic [AbW-1:0] UnitQ24    = AbW'(64'd16777216);
  localparam logic [7:0]     NodataByte = 8'd255;
  localparam logic [7:0]     ShadeMax   = 8'd254;
  localparam logic [7:0]     ShadeMin   = 8'd1;
  localparam logic [7:0]     ShadeGain  = 8'd254;

  typedef enum logic [7:0] {
    CFG_INV_X_SCALE   = 8'd0,
    CFG_INV_Y_SCALE   = 8'd1,
    CFG_NODATA_ENABLE = 8'd2,
    CFG_NODATA_VALUE  = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] inv_x_scale;
    logic signed [SampleW-1:0] inv_y_scale;
    logic                      nodata_enable;
    logic signed [SampleW-1:0] nodata_value;
  } cfg_t;

  typedef struct packed {
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic                    nodata;
  } entry_t;

endpackage

@@ rtl/hhs_front.sv @@
module hhs_front (
  input  logic                                    s_tvalid_i,
  output logic                                    s_tready_o,
  input  logic [9*hhs_pkg::SampleW-1:0]           s_tdata_i,
  input  hhs_pkg::cfg_t                           cfg_i,
  input  logic                                    q_full_i,
  output logic                                    q_push_o,
  output hhs_pkg::entry_t                         q_data_o
);
  import hhs_pkg::*;

  logic signed [GradW-1:0] smp [9];
  logic signed [GradW-1:0] west_sum, east_sum, south_sum, north_sum;
  logic [SampleW-1:0]      centre;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      smp[i] = GradW'($signed(s_tdata_i[i*SampleW +: SampleW]));
    end
  end

  assign centre    = s_tdata_i[4*SampleW +: SampleW];
  assign west_sum  = smp[0] + (smp[3] <<< 1) + smp[6];
  assign east_sum  = smp[2] + (smp[5] <<< 1) + smp[8];
  assign south_sum = smp[6] + (smp[7] <<< 1) + smp[8];
  assign north_sum = smp[0] + (smp[1] <<< 1) + smp[2];

  assign s_tready_o      = !q_full_i;
  assign q_push_o        = s_tvalid_i && !q_full_i;
  assign q_data_o.gx     = west_sum - east_sum;
  assign q_data_o.gy     = south_sum - north_sum;
  assign q_data_o.nodata = cfg_i.nodata_enable && (centre == cfg_i.nodata_value);

endmodule

@@ rtl/hhs_fifo.sv @@
module hhs_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hhs_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hhs_pkg::entry_t pop_data_o
);
  import hhs_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  entry_t          mem [Depth];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/hhs_back.sv @@
module hhs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hhs_pkg::cfg_t   cfg_i,
  input  logic            in_valid_i,
  input  hhs_pkg::entry_t in_data_i,
  output logic            in_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      shade_byte_o
);
  import hhs_pkg::*;

  logic en;
  logic out_vld_q;
  logic [7:0] out_byte_q;

  assign en           = !out_vld_q || out_ready_i;
  assign in_pop_o     = en && in_valid_i;
  assign out_valid_o  = out_vld_q;
  assign shade_byte_o = out_byte_q;

  // magnitude and sign split
  logic                  b1_vld_q, b1_nd_q, b1_na_q, b1_nb_q;
  logic [GradMagW-1:0]   b1_gxm_q, b1_gym_q;
  logic [ScaleMagW-1:0]  b1_sxm_q, b1_sym_q;
  logic [GradW-1:0]      gx_abs, gy_abs;
  logic [SampleW:0]      sx_abs, sy_abs;

  assign gx_abs = in_data_i.gx[GradW-1] ? -in_data_i.gx : in_data_i.gx;
  assign gy_abs = in_data_i.gy[GradW-1] ? -in_data_i.gy : in_data_i.gy;
  assign sx_abs = cfg_i.inv_x_scale[SampleW-1] ?
                  -{cfg_i.inv_x_scale[SampleW-1], cfg_i.inv_x_scale} :
                  {1'b0, cfg_i.inv_x_scale};
  assign sy_abs = cfg_i.inv_y_scale[SampleW-1] ?
                  -{cfg_i.inv_y_scale[SampleW-1], cfg_i.inv_y_scale} :
                  {1'b0, cfg_i.inv_y_scale};

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_nd_q  <= in_data_i.nodata;
      b1_na_q  <= in_data_i.gx[GradW-1] ^ cfg_i.inv_x_scale[SampleW-1];
      b1_nb_q  <= in_data_i.gy[GradW-1] ^ cfg_i.inv_y_scale[SampleW-1];
      b1_gxm_q <= gx_abs[GradMagW-1:0];
      b1_gym_q <= gy_abs[GradMagW-1:0];
      b1_sxm_q <= sx_abs[ScaleMagW-1:0];
      b1_sym_q <= sy_abs[ScaleMagW-1:0];
    end
  end

  // partial products
  logic                      b2_vld_q, b2_nd_q, b2_na_q, b2_nb_q;
  logic [GradMagW+15:0]      b2_pxh_q, b2_pxl_q, b2_pyh_q, b2_pyl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_nd_q  <= b1_nd_q;
      b2_na_q  <= b1_na_q;
      b2_nb_q  <= b1_nb_q;
      b2_pxh_q <= b1_gxm_q * b1_sxm_q[31:16];
      b2_pxl_q <= b1_gxm_q * b1_sxm_q[15:0];
      b2_pyh_q <= b1_gym_q * b1_sym_q[31:16];
      b2_pyl_q <= b1_gym_q * b1_sym_q[15:0];
    end
  end

  // scaled gradients
  logic               b3_vld_q, b3_nd_q, b3_na_q, b3_nb_q;
  logic [AbW-1:0]     b3_am_q, b3_bm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_nd_q <= b2_nd_q;
      b3_na_q <= b2_na_q;
      b3_nb_q <= b2_nb_q;
      b3_am_q <= AbW'({b2_pxh_q, 5'd0}) + AbW'(b2_pxl_q >> 11);
      b3_bm_q <= AbW'({b2_pyh_q, 5'd0}) + AbW'(b2_pyl_q >> 11);
    end
  end

  // common magnitude
  logic               b4_vld_q, b4_nd_q, b4_na_q, b4_nb_q;
  logic [AbW-1:0]     b4_am_q, b4_bm_q, b4_mm_q;
  logic [AbW-1:0]     ab_max;

  assign ab_max = (b3_am_q > b3_bm_q) ? b3_am_q : b3_bm_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_nd_q <= b3_nd_q;
      b4_na_q <= b3_na_q;
      b4_nb_q <= b3_nb_q;
      b4_am_q <= b3_am_q;
      b4_bm_q <= b3_bm_q;
      b4_mm_q <= (ab_max > UnitQ24) ? ab_max : UnitQ24;
    end
  end

  // normalize by 16, 8, 4, 2, 1
  logic               nm_vld_q [1:NormSteps];
  logic               nm_nd_q  [1:NormSteps];
  logic               nm_na_q  [1:NormSteps];
  logic               nm_nb_q  [1:NormSteps];
  logic [AbW-1:0]     nm_am_q  [1:NormSteps];
  logic [AbW-1:0]     nm_bm_q  [1:NormSteps];
  logic [AbW-1:0]     nm_mm_q  [1:NormSteps];
  logic [UnitW-1:0]   nm_um_q  [1:NormSteps];

  for (genvar j = 0; j < NormSteps; j++) begin : g_norm
    localparam int Sh = 16 >> j;
    logic             vin, ndin, nain, nbin, sh;
    logic [AbW-1:0]   ain, bin, min;
    logic [UnitW-1:0] uin;
    if (j == 0) begin : g_first
      assign vin  = b4_vld_q;
      assign ndin = b4_nd_q;
      assign nain = b4_na_q;
      assign nbin = b4_nb_q;
      assign ain  = b4_am_q;
      assign bin  = b4_bm_q;
      assign min  = b4_mm_q;
      assign uin  = UnitQ24[UnitW-1:0];
    end else begin : g_next
      assign vin  = nm_vld_q[j];
      assign ndin = nm_nd_q[j];
      assign nain = nm_na_q[j];
      assign nbin = nm_nb_q[j];
      assign ain  = nm_am_q[j];
      assign bin  = nm_bm_q[j];
      assign min  = nm_mm_q[j];
      assign uin  = nm_um_q[j];
    end
    assign sh = |min[AbW-1:29+Sh];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nm_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        nm_vld_q[j+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        nm_nd_q[j+1] <= ndin;
        nm_na_q[j+1] <= nain;
        nm_nb_q[j+1] <= nbin;
        nm_am_q[j+1] <= sh ? (ain >> Sh) : ain;
        nm_bm_q[j+1] <= sh ? (bin >> Sh) : bin;
        nm_mm_q[j+1] <= sh ? (min >> Sh) : min;
        nm_um_q[j+1] <= sh ? (uin >> Sh) : uin;
      end
    end
  end

  // squares and light term
  logic                     p_vld_q, p_nd_q;
  logic [2*NormW-1:0]       p_asq_q, p_bsq_q;
  logic [2*UnitW-1:0]       p_usq_q;
  logic [UnitW+30:0]        p_us_q;
  logic signed [31:0]       p_apb_q;
  logic signed [31:0]       sa, sb;
  logic [NormW-1:0]         an, bn;

  assign an = nm_am_q[NormSteps][NormW-1:0];
  assign bn = nm_bm_q[NormSteps][NormW-1:0];
  assign sa = nm_na_q[NormSteps] ? -$signed({2'b00, an}) : $signed({2'b00, an});
  assign sb = nm_nb_q[NormSteps] ? -$signed({2'b00, bn}) : $signed({2'b00, bn});

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_nd_q  <= nm_nd_q[NormSteps];
      p_asq_q <= an * an;
      p_bsq_q <= bn * bn;
      p_usq_q <= nm_um_q[NormSteps] * nm_um_q[NormSteps];
      p_us_q  <= nm_um_q[NormSteps] * Sqrt2Q30;
      p_apb_q <= sa + sb;
    end
  end

  // radicand and numerator
  logic                  qs_vld_q, qs_nd_q;
  logic [QW-1:0]         qs_q_q;
  logic signed [TW-1:0]  qs_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      qs_nd_q <= p_nd_q;
      qs_q_q  <= QW'(p_asq_q) + QW'(p_bsq_q) + QW'(p_usq_q);
      qs_t_q  <= $signed({7'd0, p_us_q[UnitW+30:30]}) - $signed({p_apb_q[31], p_apb_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q <= 1'b0;
      b2_vld_q <= 1'b0;
      b3_vld_q <= 1'b0;
      b4_vld_q <= 1'b0;
      p_vld_q  <= 1'b0;
      qs_vld_q <= 1'b0;
    end else if (en) begin
      b1_vld_q <= in_valid_i;
      b2_vld_q <= b1_vld_q;
      b3_vld_q <= b2_vld_q;
      b4_vld_q <= b3_vld_q;
      p_vld_q  <= nm_vld_q[NormSteps];
      qs_vld_q <= p_vld_q;
    end
  end

  // square root, one bit a stage
  logic                  sq_vld_q  [1:SqrtSteps];
  logic                  sq_nd_q   [1:SqrtSteps];
  logic [QW-1:0]         sq_q_q    [1:SqrtSteps];
  logic signed [TW-1:0]  sq_t_q    [1:SqrtSteps];
  logic [RootW+1:0]      sq_rem_q  [1:SqrtSteps];
  logic [RootW-1:0]      sq_root_q [1:SqrtSteps];

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    logic                 vin, ndin, ge;
    logic [QW-1:0]        qin;
    logic signed [TW-1:0] tin;
    logic [RootW+1:0]     rin;
    logic [RootW-1:0]     rtin;
    logic [RootW+3:0]     cat, trial, sub;
    if (j == 0) begin : g_first
      assign vin  = qs_vld_q;
      assign ndin = qs_nd_q;
      assign qin  = qs_q_q;
      assign tin  = qs_t_q;
      assign rin  = '0;
      assign rtin = '0;
    end else begin : g_next
      assign vin  = sq_vld_q[j];
      assign ndin = sq_nd_q[j];
      assign qin  = sq_q_q[j];
      assign tin  = sq_t_q[j];
      assign rin  = sq_rem_q[j];
      assign rtin = sq_root_q[j];
    end
    assign cat   = {rin, qin[QW-1-2*j -: 2]};
    assign sub   = {2'b00, rtin, 2'b01};
    assign ge    = (cat >= sub);
    assign trial = cat - sub;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        sq_vld_q[j+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_nd_q[j+1]   <= ndin;
        sq_q_q[j+1]    <= qin;
        sq_t_q[j+1]    <= tin;
        sq_rem_q[j+1]  <= ge ? trial[RootW+1:0] : cat[RootW+1:0];
        sq_root_q[j+1] <= {rtin[RootW-2:0], ge};
      end
    end
  end

  // division, one quotient bit a stage
  logic                  dv_vld_q [1:DivSteps];
  logic                  dv_nd_q  [1:DivSteps];
  logic signed [TW-1:0]  dv_t_q   [1:DivSteps];
  logic [RootW-1:0]      dv_d_q   [1:DivSteps];
  logic [RootW-1:0]      dv_rem_q [1:DivSteps];
  logic [QuoW-1:0]       dv_quo_q [1:DivSteps];

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    logic                 vin, ndin, ge;
    logic signed [TW-1:0] tin;
    logic [RootW-1:0]     din, rin;
    logic [QuoW-1:0]      qoin, nlo;
    logic [RootW:0]       cat;
    if (j == 0) begin : g_first
      assign vin  = sq_vld_q[SqrtSteps];
      assign ndin = sq_nd_q[SqrtSteps];
      assign tin  = sq_t_q[SqrtSteps];
      assign din  = (sq_root_q[SqrtSteps] == '0) ? RootW'(1) : sq_root_q[SqrtSteps];
      assign rin  = RootW'(sq_t_q[SqrtSteps][TW-1:3]);
      assign qoin = '0;
    end else begin : g_next
      assign vin  = dv_vld_q[j];
      assign ndin = dv_nd_q[j];
      assign tin  = dv_t_q[j];
      assign din  = dv_d_q[j];
      assign rin  = dv_rem_q[j];
      assign qoin = dv_quo_q[j];
    end
    assign nlo = {tin[2:0], 15'd0};
    assign cat = {rin, nlo[QuoW-1-j]};
    assign ge  = (cat >= {1'b0, din});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j+1] <= vin;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_nd_q[j+1]  <= ndin;
        dv_t_q[j+1]   <= tin;
        dv_d_q[j+1]   <= din;
        dv_rem_q[j+1] <= ge ? RootW'(cat - {1'b0, din}) : RootW'(cat);
        dv_quo_q[j+1] <= {qoin[QuoW-2:0], ge};
      end
    end
  end

  // map to byte
  logic [QuoW-1:0]       quo;
  logic signed [TW-1:0]  tf;
  logic [23:0]           sc;
  logic [7:0]            byte_d;

  assign quo = dv_quo_q[DivSteps];
  assign tf  = dv_t_q[DivSteps];
  assign sc  = ShadeGain * quo[15:0];

  always_comb begin
    if (dv_nd_q[DivSteps]) begin
      byte_d = NodataByte;
    end else if (tf[TW-1] || (tf == '0)) begin
      byte_d = ShadeMin;
    end else if (|quo[QuoW-1:16]) begin
      byte_d = ShadeMax;
    end else begin
      byte_d = ShadeMin + sc[23:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_byte_q <= byte_d;
    end
  end

endmodule

@@ rtl/horn_hillshade_pixel_core.sv @@
// Channel  Dir  Payload                                   Handshake
// s_*      in   tdata: nine Q24.8 samples, 32 bits each    s_tvalid_i / s_tready_o
// m_*      out  tdata: shade_byte                          m_tvalid_o / m_tready_i
// cfg_*    in   cfg_index_i register, cfg_data_i value     cfg_valid_i / cfg_ready_o
//
// One window a cycle sustained while m_tready_i is held high; the back pipeline
// includes the 31-stage square root and the 18-stage divider.
// Reset clears the queue, all stage valid bits and the registers to defaults.
// The back pipeline holds while a result waits; input stalls only when the
// queue is full.
module horn_hillshade_pixel_core #(
  parameter int FifoDepth = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // nw, n, ne, west, centre, east, sw, s, se samples, 32 bits each
  input  logic [287:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // shade_byte
  output logic [7:0]   m_tdata_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import hhs_pkg::*;

  cfg_t   cfg_q;
  logic   q_full, q_push, q_valid, q_pop;
  entry_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_x_scale   <= 32'sh0100_0000;
      cfg_q.inv_y_scale   <= 32'sh0100_0000;
      cfg_q.nodata_enable <= 1'b0;
      cfg_q.nodata_value  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INV_X_SCALE:   cfg_q.inv_x_scale   <= cfg_data_i;
        CFG_INV_Y_SCALE:   cfg_q.inv_y_scale   <= cfg_data_i;
        CFG_NODATA_ENABLE: cfg_q.nodata_enable <= cfg_data_i[0];
        CFG_NODATA_VALUE:  cfg_q.nodata_value  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hhs_front u_front (
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  hhs_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  hhs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (q_valid),
    .in_data_i    (q_rdata),
    .in_pop_o     (q_pop),
    .out_valid_o  (m_tvalid_o),
    .out_ready_i  (m_tready_i),
    .shade_byte_o (m_tdata_o)
  );

endmodule
